// ===== src/imuyaw_pkg.sv =====
// imuyaw package: widths, register indexes, constants and saturation helper
`timescale 1ns / 1ps
package imuyaw_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [CFG_IDX_W-1:0] CFG_GYRO_LPF_ALPHA = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COMP_ALPHA     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TILT_THRESHOLD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_DECAY    = 3'd5;

	localparam logic [1:0] MODE_UPDATE   = 2'd0;
	localparam logic [1:0] MODE_ZERO_YAW = 2'd1;
	localparam logic [1:0] MODE_CLEAR    = 2'd2;

	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// 57.2958 in Q16
	localparam logic signed [MUL_B_W-1:0] TILT_K = 25'sd3754938;

	localparam logic signed [17:0] Q16_ONE = 18'sd65536;

	function automatic logic signed [63:0] sat_s(input logic signed [63:0] v,
		input int unsigned w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			return hi;
		end else if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

endpackage

// ===== src/imuyaw_in_if.sv =====
// imuyaw sample channel: valid, ready and the sample payload
`timescale 1ns / 1ps
interface imuyaw_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [15:0] gyro_rate;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;

	modport source (output valid, mode, gyro_rate, accel_x, accel_y, input ready);
	modport sink (input valid, mode, gyro_rate, accel_x, accel_y, output ready);
endinterface

// ===== src/imuyaw_out_if.sv =====
// imuyaw result channel: valid, ready and the attitude payload
`timescale 1ns / 1ps
interface imuyaw_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] yaw_angle;
	logic signed [19:0] pitch_angle;
	logic signed [19:0] roll_angle;
	logic signed [23:0] rate_filtered;
	logic               drift_fixed;

	modport source (output valid, yaw_angle, pitch_angle, roll_angle, rate_filtered,
		drift_fixed, input ready);
	modport sink (input valid, yaw_angle, pitch_angle, roll_angle, rate_filtered,
		drift_fixed, output ready);
endinterface

// ===== src/imuyaw_mul.sv =====
// imuyaw shared signed multiplier with registered product
`timescale 1ns / 1ps
module imuyaw_mul (
	input  logic                                     clk,
	input  logic signed [imuyaw_pkg::MUL_A_W-1:0]    a,
	input  logic signed [imuyaw_pkg::MUL_B_W-1:0]    b,
	output logic signed [imuyaw_pkg::MUL_P_W-1:0]    p_q
);

	always_ff @(posedge clk) begin
		p_q <= imuyaw_pkg::MUL_P_W'(a) * imuyaw_pkg::MUL_P_W'(b);
	end

endmodule

// ===== src/imu_yaw_integrate_complementary_tilt.sv =====
// imuyaw top level: sequencer, state, configuration and result register
// sample update: steps run from the gyro filter through the level check, plus a yaw decay step when it applies
// zero yaw, clear and unused modes: the state is set in the first ST_RUN step, then ST_OUT loads the result
// ready again once the result register is loaded, which a held result with results.ready low delays
// a new sample waits while one is in progress on the single 34x25 multiplier, used up to nine times per sample
// arst_n clears state, control and result valid and restores register defaults
`timescale 1ns / 1ps
module imu_yaw_integrate_complementary_tilt (
	input  logic                                  clk,
	input  logic                                  arst_n,
	imuyaw_in_if.sink                             samples,
	imuyaw_out_if.source                          results,
	input  logic                                  cfg_we,
	input  logic [imuyaw_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [imuyaw_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam logic [3:0] SP_LPF_MUL   = 4'd0;
	localparam logic [3:0] SP_RATE      = 4'd1;
	localparam logic [3:0] SP_YAW_MUL   = 4'd2;
	localparam logic [3:0] SP_YAW       = 4'd3;
	localparam logic [3:0] SP_PITCH_W   = 4'd4;
	localparam logic [3:0] SP_PITCH_K   = 4'd5;
	localparam logic [3:0] SP_PITCH     = 4'd6;
	localparam logic [3:0] SP_ROLL_W    = 4'd7;
	localparam logic [3:0] SP_ROLL_K    = 4'd8;
	localparam logic [3:0] SP_ROLL      = 4'd9;
	localparam logic [3:0] SP_LEVEL     = 4'd10;
	localparam logic [3:0] SP_DECAY     = 4'd11;

	logic [16:0] gyro_lpf_alpha_q;
	logic [16:0] comp_alpha_q;
	logic [19:0] step_time_q;
	logic [22:0] rate_threshold_q;
	logic [18:0] tilt_threshold_q;
	logic [16:0] drift_decay_q;

	logic signed [31:0] yaw_q;
	logic signed [19:0] pitch_q;
	logic signed [19:0] roll_q;
	logic signed [23:0] rate_q;
	logic               fixed_q;

	logic [1:0] state_q;
	logic [3:0] step_q;

	logic [1:0]         mode_q;
	logic signed [15:0] gyro_q;
	logic signed [15:0] ax_q;
	logic signed [15:0] ay_q;
	logic signed [59:0] acc_q;

	logic                                     out_valid_q;
	logic signed [31:0]                       out_yaw_q;
	logic signed [19:0]                       out_pitch_q;
	logic signed [19:0]                       out_roll_q;
	logic signed [23:0]                       out_rate_q;
	logic                                     out_fixed_q;

	logic signed [imuyaw_pkg::MUL_A_W-1:0] mul_a;
	logic signed [imuyaw_pkg::MUL_B_W-1:0] mul_b;
	logic signed [imuyaw_pkg::MUL_P_W-1:0] p_q;

	logic               accept;
	logic               out_load;
	logic signed [24:0] rate_diff;
	logic signed [17:0] comp_rest;
	logic signed [63:0] rate_new;
	logic signed [63:0] yaw_add;
	logic signed [63:0] yaw_decayed;
	logic signed [59:0] tilt_sum;
	logic signed [63:0] tilt_new;
	logic [23:0]        rate_mag;
	logic [19:0]        pitch_mag;
	logic [19:0]        roll_mag;
	logic               level;

	assign accept   = samples.valid && samples.ready;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || results.ready);
	assign samples.ready = (state_q == ST_IDLE);

	assign rate_diff = $signed({{5{gyro_q[15]}}, gyro_q, 4'b0000}) - 25'(rate_q);
	assign comp_rest = imuyaw_pkg::Q16_ONE - $signed({1'b0, comp_alpha_q});

	assign rate_new    = imuyaw_pkg::sat_s(64'(rate_q) + 64'(p_q >>> 16), 24);
	assign yaw_add     = imuyaw_pkg::sat_s(64'(yaw_q) + 64'(p_q >>> 16), 32);
	assign yaw_decayed = imuyaw_pkg::sat_s(64'(p_q >>> 16), 32);
	assign tilt_sum    = acc_q + 60'(p_q);
	assign tilt_new    = imuyaw_pkg::sat_s(64'(tilt_sum >>> 34), 20);

	assign rate_mag  = rate_q[23] ? 24'(~rate_q + 24'sd1) : 24'(rate_q);
	assign pitch_mag = pitch_q[19] ? 20'(~pitch_q + 20'sd1) : 20'(pitch_q);
	assign roll_mag  = roll_q[19] ? 20'(~roll_q + 20'sd1) : 20'(roll_q);
	assign level = (rate_mag < {1'b0, rate_threshold_q})
		&& (pitch_mag < {1'b0, tilt_threshold_q})
		&& (roll_mag < {1'b0, tilt_threshold_q});

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			SP_LPF_MUL: begin
				mul_a = 34'(rate_diff);
				mul_b = 25'($signed({1'b0, gyro_lpf_alpha_q}));
			end
			SP_YAW_MUL: begin
				mul_a = 34'(rate_q);
				mul_b = 25'($signed({1'b0, step_time_q}));
			end
			SP_YAW: begin
				mul_a = 34'(pitch_q);
				mul_b = 25'($signed({1'b0, comp_alpha_q}));
			end
			SP_PITCH_W: begin
				mul_a = 34'(ax_q);
				mul_b = 25'(comp_rest);
			end
			SP_PITCH_K: begin
				mul_a = $signed(p_q[33:0]);
				mul_b = imuyaw_pkg::TILT_K;
			end
			SP_PITCH: begin
				mul_a = 34'(roll_q);
				mul_b = 25'($signed({1'b0, comp_alpha_q}));
			end
			SP_ROLL_W: begin
				mul_a = 34'(ay_q);
				mul_b = 25'(comp_rest);
			end
			SP_ROLL_K: begin
				mul_a = $signed(p_q[33:0]);
				mul_b = imuyaw_pkg::TILT_K;
			end
			SP_LEVEL: begin
				mul_a = 34'(yaw_q);
				mul_b = 25'($signed({1'b0, drift_decay_q}));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	imuyaw_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_lpf_alpha_q <= 17'd6554;
			comp_alpha_q     <= 17'd63570;
			step_time_q      <= 20'd10486;
			rate_threshold_q <= 23'd512;
			tilt_threshold_q <= 19'd12288;
			drift_decay_q    <= 17'd65470;
		end else if (cfg_we) begin
			case (cfg_index)
				imuyaw_pkg::CFG_GYRO_LPF_ALPHA: gyro_lpf_alpha_q <= cfg_data[16:0];
				imuyaw_pkg::CFG_COMP_ALPHA:     comp_alpha_q     <= cfg_data[16:0];
				imuyaw_pkg::CFG_STEP_TIME:      step_time_q      <= cfg_data[19:0];
				imuyaw_pkg::CFG_RATE_THRESHOLD: rate_threshold_q <= cfg_data[22:0];
				imuyaw_pkg::CFG_TILT_THRESHOLD: tilt_threshold_q <= cfg_data[18:0];
				imuyaw_pkg::CFG_DRIFT_DECAY:    drift_decay_q    <= cfg_data[16:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= SP_LPF_MUL;
			yaw_q   <= '0;
			pitch_q <= '0;
			roll_q  <= '0;
			rate_q  <= '0;
			fixed_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
						step_q  <= SP_LPF_MUL;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 4'd1;
					case (step_q)
						SP_LPF_MUL: begin
							fixed_q <= 1'b0;
							if (mode_q == imuyaw_pkg::MODE_ZERO_YAW) begin
								yaw_q   <= '0;
								state_q <= ST_OUT;
							end else if (mode_q == imuyaw_pkg::MODE_CLEAR) begin
								yaw_q   <= '0;
								pitch_q <= '0;
								roll_q  <= '0;
								rate_q  <= '0;
								state_q <= ST_OUT;
							end else if (mode_q != imuyaw_pkg::MODE_UPDATE) begin
								state_q <= ST_OUT;
							end
						end
						SP_RATE:  rate_q  <= rate_new[23:0];
						SP_YAW:   yaw_q   <= yaw_add[31:0];
						SP_PITCH: pitch_q <= tilt_new[19:0];
						SP_ROLL:  roll_q  <= tilt_new[19:0];
						SP_LEVEL: begin
							if (level) begin
								fixed_q <= 1'b1;
							end else begin
								state_q <= ST_OUT;
							end
						end
						SP_DECAY: begin
							yaw_q   <= yaw_decayed[31:0];
							state_q <= ST_OUT;
						end
						default: begin
						end
					endcase
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// sample latch and tilt accumulator
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= samples.mode;
			gyro_q <= samples.gyro_rate;
			ax_q   <= samples.accel_x;
			ay_q   <= samples.accel_y;
		end
		if ((state_q == ST_RUN) && ((step_q == SP_PITCH_W) || (step_q == SP_ROLL_W))) begin
			acc_q <= 60'(p_q) <<< 18;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_yaw_q   <= yaw_q;
			out_pitch_q <= pitch_q;
			out_roll_q  <= roll_q;
			out_rate_q  <= rate_q;
			out_fixed_q <= fixed_q;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.yaw_angle     = out_yaw_q;
	assign results.pitch_angle   = out_pitch_q;
	assign results.roll_angle    = out_roll_q;
	assign results.rate_filtered = out_rate_q;
	assign results.drift_fixed   = out_fixed_q;

endmodule

// ===== src/imuyaw_chk.sv =====
// imuyaw port checker and its bind to the top level
`timescale 1ns / 1ps
module imuyaw_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [1:0] in_mode,
	input logic       out_valid,
	input logic       out_ready
);

	// busy right after an item is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("imuyaw: ready right after accept");

	// an update item keeps the block busy past the point that a_busy_after_accept checks
	a_update_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_mode == imuyaw_pkg::MODE_UPDATE) |=> ##1 !in_ready)
		else $error("imuyaw: update finished too early");

	// a result appears only from the busy sequencer
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("imuyaw: result without work");

	// a pending result is held until taken
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("imuyaw: result dropped");

endmodule

bind imu_yaw_integrate_complementary_tilt imuyaw_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.in_mode   (samples.mode),
	.out_valid (results.valid),
	.out_ready (results.ready)
);

// ===== tb/sv/imuyaw_attitude_checker.sv =====
// imuyaw checker: follows register writes, predicts each sample's attitude and compares results
`timescale 1ns / 1ps
module imuyaw_attitude_checker
	import imuyaw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	imuyaw_in_if                  samples,
	imuyaw_out_if                 results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending,
	output int                    checked,
	output int                    decays
);

	typedef struct packed {
		logic signed [31:0] yaw;
		logic signed [19:0] pitch;
		logic signed [19:0] roll;
		logic signed [23:0] rate;
		logic               decayed;
	} attitude_t;

	attitude_t attitude_q[$];

	longint yaw_acc;
	longint pitch_acc;
	longint roll_acc;
	longint rate_acc;

	longint lpf_alpha;
	longint blend_alpha;
	longint period_q20;
	longint rate_limit;
	longint tilt_limit;
	longint decay_gain;

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		hi = (longint'(1) <<< (w - 1)) - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < -hi - 1) begin
			return -hi - 1;
		end
		return v;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// previous tilt weighted by the blend alpha, fresh tilt from accel scaled to degrees
	function automatic longint blend_tilt(input longint prev, input longint accel);
		longint held;
		longint fresh;
		held = blend_alpha * prev * 262144;
		fresh = (65536 - blend_alpha) * (accel * longint'(TILT_K));
		return clamp((held + fresh) >>> 34, 20);
	endfunction

	function automatic attitude_t advance_attitude(input logic [1:0] mode,
		input logic signed [15:0] gyro, input logic signed [15:0] ax,
		input logic signed [15:0] ay);
		attitude_t r;
		longint gyro_q8;
		r.decayed = 1'b0;
		case (mode)
			MODE_UPDATE: begin
				gyro_q8 = longint'(gyro) * 16;
				rate_acc = clamp(rate_acc + ((lpf_alpha * (gyro_q8 - rate_acc)) >>> 16), 24);
				yaw_acc = clamp(yaw_acc + ((rate_acc * period_q20) >>> 16), 32);
				pitch_acc = blend_tilt(pitch_acc, longint'(ax));
				roll_acc = blend_tilt(roll_acc, longint'(ay));
				if (magnitude(rate_acc) < rate_limit && magnitude(pitch_acc) < tilt_limit &&
					magnitude(roll_acc) < tilt_limit) begin
					yaw_acc = clamp((yaw_acc * decay_gain) >>> 16, 32);
					r.decayed = 1'b1;
				end
			end
			MODE_ZERO_YAW: begin
				yaw_acc = 0;
			end
			MODE_CLEAR: begin
				yaw_acc = 0;
				pitch_acc = 0;
				roll_acc = 0;
				rate_acc = 0;
			end
			default: begin
			end
		endcase
		r.yaw = yaw_acc[31:0];
		r.pitch = pitch_acc[19:0];
		r.roll = roll_acc[19:0];
		r.rate = rate_acc[23:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		attitude_t want;
		if (!arst_n) begin
			lpf_alpha = 6554;
			blend_alpha = 63570;
			period_q20 = 10486;
			rate_limit = 512;
			tilt_limit = 12288;
			decay_gain = 65470;
			yaw_acc = 0;
			pitch_acc = 0;
			roll_acc = 0;
			rate_acc = 0;
			attitude_q.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			decays = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_GYRO_LPF_ALPHA: lpf_alpha = longint'(cfg_data[16:0]);
					CFG_COMP_ALPHA:     blend_alpha = longint'(cfg_data[16:0]);
					CFG_STEP_TIME:      period_q20 = longint'(cfg_data[19:0]);
					CFG_RATE_THRESHOLD: rate_limit = longint'(cfg_data[22:0]);
					CFG_TILT_THRESHOLD: tilt_limit = longint'(cfg_data[18:0]);
					CFG_DRIFT_DECAY:    decay_gain = longint'(cfg_data[16:0]);
					default: begin
					end
				endcase
			end
			if (samples.valid && samples.ready) begin
				attitude_q.push_back(advance_attitude(samples.mode, samples.gyro_rate,
					samples.accel_x, samples.accel_y));
			end
			if (results.valid && results.ready) begin
				checked++;
				if (attitude_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result with no sample pending: yaw %0d pitch %0d roll %0d",
							$realtime, results.yaw_angle, results.pitch_angle, results.roll_angle);
					end
				end else begin
					want = attitude_q.pop_front();
					if (want.decayed) begin
						decays++;
					end
					if (results.yaw_angle !== want.yaw || results.pitch_angle !== want.pitch ||
						results.roll_angle !== want.roll || results.rate_filtered !== want.rate ||
						results.drift_fixed !== want.decayed) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: attitude mismatch", $realtime);
							$display("  expected yaw %0d pitch %0d roll %0d rate %0d decay %0b",
								want.yaw, want.pitch, want.roll, want.rate, want.decayed);
							$display("  actual   yaw %0d pitch %0d roll %0d rate %0d decay %0b",
								results.yaw_angle, results.pitch_angle, results.roll_angle,
								results.rate_filtered, results.drift_fixed);
						end
					end
				end
			end
			pending = attitude_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_imu_yaw_integrate_complementary_tilt.sv =====
// imuyaw testbench top: clock, reset, sample and register stimulus, back-pressure, verdict
`timescale 1ns / 1ps
module tb_imu_yaw_integrate_complementary_tilt;
	import imuyaw_pkg::*;

	localparam logic [1:0]           MODE_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd7;
	localparam int                   RANDOM_PHASES = 8;
	localparam int                   PHASE_SAMPLES = 100;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bit idle_on = 1'b1;
	int ready_hold = 0;
	int errors;
	int pending;
	int checked;
	int decays;
	int sent = 0;
	int settings_used = 0;

	imuyaw_in_if  samples_if ();
	imuyaw_out_if results_if ();

	imu_yaw_integrate_complementary_tilt u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	imuyaw_attitude_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending),
		.checked   (checked),
		.decays    (decays)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			results_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			ready_hold <= $urandom_range(0, 5);
			results_if.ready <= 1'b0;
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	task automatic send_sample(input logic [1:0] mode, input logic [15:0] gyro,
		input logic [15:0] ax, input logic [15:0] ay);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.mode <= mode;
		samples_if.gyro_rate <= gyro;
		samples_if.accel_x <= ax;
		samples_if.accel_y <= ay;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		sent++;
	endtask

	function automatic logic [15:0] corner_value();
		case ($urandom_range(0, 4))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'h0001;
		endcase
	endfunction

	// level runs keep rate and tilt small so the yaw decay gets a chance to fire
	task automatic send_random(input int kind);
		int pick;
		int g;
		int x;
		int y;
		logic [1:0] mode;
		logic [15:0] gyro;
		logic [15:0] ax;
		logic [15:0] ay;
		pick = $urandom_range(0, 99);
		mode = (pick < 90) ? MODE_UPDATE : (pick < 94) ? MODE_ZERO_YAW :
			(pick < 97) ? MODE_CLEAR : MODE_SPARE;
		case (kind)
			0: begin
				gyro = 16'($urandom);
				ax = 16'($urandom);
				ay = 16'($urandom);
			end
			1, 2: begin
				g = $urandom_range(0, 80);
				x = $urandom_range(0, 1600);
				y = $urandom_range(0, 1600);
				g = g - 40;
				x = x - 800;
				y = y - 800;
				gyro = g[15:0];
				ax = x[15:0];
				ay = y[15:0];
			end
			default: begin
				gyro = corner_value();
				ax = corner_value();
				ay = corner_value();
			end
		endcase
		send_sample(mode, gyro, ax, ay);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input int unsigned lpf, input int unsigned comp,
		input int unsigned period, input int unsigned rate_thr, input int unsigned tilt_thr,
		input int unsigned decay);
		write_reg(CFG_GYRO_LPF_ALPHA, lpf);
		write_reg(CFG_COMP_ALPHA, comp);
		write_reg(CFG_STEP_TIME, period);
		write_reg(CFG_RATE_THRESHOLD, rate_thr);
		write_reg(CFG_TILT_THRESHOLD, tilt_thr);
		write_reg(CFG_DRIFT_DECAY, decay);
		settings_used++;
	endtask

	task automatic drain_results();
		int guard;
		samples_if.valid <= 1'b0;
		@(posedge clk);
		for (guard = 0; pending != 0 && guard < 5000; guard++) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		int count;
		int kind;
		int len;
		samples_if.valid = 1'b0;
		samples_if.mode = MODE_UPDATE;
		samples_if.gyro_rate = '0;
		samples_if.accel_x = '0;
		samples_if.accel_y = '0;
		results_if.ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a write to an unused index that must change nothing, then samples under the reset defaults
		write_reg(CFG_SPARE, 23'h7FFFFF);
		send_sample(MODE_UPDATE, 16'h0000, 16'h0000, 16'h0000);
		send_sample(MODE_UPDATE, 16'h7FFF, 16'h7FFF, 16'h8000);
		send_sample(MODE_UPDATE, 16'h8000, 16'h8000, 16'h7FFF);
		send_sample(MODE_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(MODE_UPDATE, 16'h0001, 16'h0001, 16'h0001);
		send_sample(MODE_ZERO_YAW, 16'h1234, 16'h5678, 16'h9ABC);
		send_sample(MODE_SPARE, 16'h7FFF, 16'h8000, 16'h7FFF);
		send_sample(MODE_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_sample(MODE_UPDATE, 16'h0000, 16'h0000, 16'h0000);
		send_sample(MODE_UPDATE, 16'd20, 16'd300, 16'hFED4);
		drain_results();

		// decay above one drives yaw into saturation both ways
		apply_setting(65536, 0, 1048575, 8388607, 524287, 131071);
		repeat (8) send_sample(MODE_UPDATE, 16'h7FFF, 16'h0000, 16'h0000);
		send_sample(MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000);
		repeat (8) send_sample(MODE_UPDATE, 16'h8000, 16'h0000, 16'h0000);
		drain_results();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: apply_setting(6554, 63570, 10486, 512, 12288, 65470);
				1: apply_setting(65536, 65536, 1048575, 8388607, 524287, 65536);
				2: apply_setting(0, 0, 0, 0, 0, 0);
				3: apply_setting(131071, 131071, 1048575, 8388607, 524287, 131071);
				default: apply_setting(
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) :
						$urandom_range(0, 65536),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) :
						$urandom_range(49152, 65536),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 1048575) :
						$urandom_range(1000, 40000),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 8388607) :
						$urandom_range(0, 4096),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 524287) :
						$urandom_range(0, 40000),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) :
						$urandom_range(60000, 65536));
			endcase
			idle_on = (p != 2 && p != RANDOM_PHASES - 1);
			count = 0;
			while (count < PHASE_SAMPLES) begin
				kind = $urandom_range(0, 3);
				len = $urandom_range(1, 24);
				repeat (len) begin
					send_random(kind);
					count++;
				end
			end
			drain_results();
		end

		$display("covered %0d samples under %0d register settings: %0d results checked, %0d with yaw decay",
			sent, settings_used, checked, decays);
		$display("failures: %0d mismatched or unexpected, %0d results never arrived",
			errors, pending);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
